// File: hw/rtl/tfd_pkg.sv
`timescale 1ns / 1ps

package tfd_pkg;

    // Framing bytes
    localparam logic [7:0] MARK_BYTE       = 8'h7E;
    localparam logic [7:0] ESCAPE_BYTE     = 8'h7F;
    localparam logic [7:0] COMMAND_CHANNEL = 8'h00;

    // Result kind codes
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_COMMAND = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // One parsed result beat
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] channel;
        logic [7:0] value;
        logic [7:0] command_arg;
    } t_result;

endpackage

// File: hw/rtl/tfd_parser.sv
`timescale 1ns / 1ps

module tfd_parser import tfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_result    o_result
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_CHANNEL = 3'd1,
        PH_CMD     = 3'd2,
        PH_ARG     = 3'd3,
        PH_TRAIL   = 3'd4,
        PH_DATA    = 3'd5,
        PH_ESCAPED = 3'd6
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_channel, n_channel;
    logic [7:0] r_held, n_held;
    t_result    n_result;

    // Decode one byte against the current frame phase
    always_comb begin
        n_phase              = r_phase;
        n_channel            = r_channel;
        n_held               = r_held;
        n_result.valid       = 1'b0;
        n_result.kind        = KIND_DATA;
        n_result.channel     = 8'h00;
        n_result.value       = 8'h00;
        n_result.command_arg = 8'h00;
        case (r_phase)
            PH_CHANNEL: begin
                n_channel = i_byte;
                n_phase   = (i_byte == COMMAND_CHANNEL) ? PH_CMD : PH_DATA;
            end
            PH_CMD: begin
                n_held  = i_byte;
                n_phase = PH_ARG;
            end
            PH_ARG: begin
                n_phase              = PH_TRAIL;
                n_result.valid       = 1'b1;
                n_result.kind        = KIND_COMMAND;
                n_result.channel     = COMMAND_CHANNEL;
                n_result.value       = r_held;
                n_result.command_arg = i_byte;
            end
            PH_TRAIL: begin
                // drop the trailer byte unchecked
                n_phase = PH_HUNT;
            end
            PH_DATA: begin
                if (i_byte == MARK_BYTE) begin
                    n_phase          = PH_HUNT;
                    n_result.valid   = 1'b1;
                    n_result.kind    = KIND_END;
                    n_result.channel = r_channel;
                end else if (i_byte == ESCAPE_BYTE) begin
                    n_phase = PH_ESCAPED;
                end else begin
                    n_result.valid   = 1'b1;
                    n_result.kind    = KIND_DATA;
                    n_result.channel = r_channel;
                    n_result.value   = i_byte;
                end
            end
            PH_ESCAPED: begin
                n_phase          = PH_DATA;
                n_result.valid   = 1'b1;
                n_result.kind    = KIND_DATA;
                n_result.channel = r_channel;
                n_result.value   = i_byte;
            end
            default: begin
                // hunting, and the unused phase code
                if (i_byte == MARK_BYTE) begin
                    n_phase = PH_CHANNEL;
                end else begin
                    n_phase        = PH_HUNT;
                    n_result.valid = 1'b1;
                    n_result.kind  = KIND_ERROR;
                    n_result.value = i_byte;
                end
            end
        endcase
    end

    // Advance frame state on each stepped beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_channel <= 8'h00;
            r_held    <= 8'h00;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_channel <= n_channel;
            r_held    <= n_held;
        end
    end

    assign o_result = n_result;

endmodule

// File: hw/rtl/tunnel_frame_deframer_demux_top.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake               Payload
// rx       in   i_rx_valid/o_rx_stall   i_rx_byte
// out      out  o_out_valid/i_out_stall o_kind, o_channel, o_value, o_command_arg
//
// One byte per cycle while the output is not stalled: an input register feeds the
// combinational frame parser, whose result is registered in the output register.
// Synchronous active-low reset puts the parser into start-byte hunt.
// A byte that yields no result still waits for a free output slot.
// o_rx_stall rises only while the output register is held by i_out_stall.

module tunnel_frame_deframer_demux_top import tfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_channel,
    output logic [7:0] o_value,
    output logic [7:0] o_command_arg
);

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_out_vld;
    logic [1:0] r_kind;
    logic [7:0] r_channel;
    logic [7:0] r_value;
    logic [7:0] r_arg;
    logic       w_step;
    logic       w_rx_take;
    t_result    w_result;

    // Step the parser when the result slot is free or draining
    assign w_step     = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_rx_stall = r_in_vld && !w_step;
    assign w_rx_take  = i_rx_valid && !o_rx_stall;

    tfd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .o_result (w_result)
    );

    // Hold the incoming beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_rx_take) begin
            r_in_vld <= 1'b1;
        end else if (w_step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rx_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Load or drain the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_step) begin
            r_out_vld <= w_result.valid;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_result.valid) begin
            r_kind    <= w_result.kind;
            r_channel <= w_result.channel;
            r_value   <= w_result.value;
            r_arg     <= w_result.command_arg;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_kind        = r_kind;
    assign o_channel     = r_channel;
    assign o_value       = r_value;
    assign o_command_arg = r_arg;

`ifndef SYNTH
    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> r_in_vld)
        else $error("input stalled with no held beat");

    a_free_slot_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> !o_rx_stall)
        else $error("input stalled while result slot is empty");

    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_kind == KIND_ERROR) |-> (r_channel == 8'h00 && r_arg == 8'h00))
        else $error("error result carries channel or argument");

    a_command_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_kind == KIND_COMMAND) |-> (r_channel == COMMAND_CHANNEL))
        else $error("command result on a data channel");

    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_kind == KIND_END) |-> (r_value == 8'h00 && r_arg == 8'h00))
        else $error("frame end carries a value");
`endif

endmodule
